// ----- hdl/soru_pkg.sv -----
`default_nettype none

package soru_pkg;

   localparam int SLOT_FIELD_W  = 4;
   localparam int COUNT_FIELD_W = 5;
   localparam int POOL_W        = 5;
   localparam logic [POOL_W-1:0] POOL_RESET = 5'd16;

   // cell positions and slot ids carried between cells, sized for the largest pool
   localparam int POS_W = 6;
   localparam int LEN_W = 7;

   typedef enum logic {
      ACT_ALLOC   = 1'b0,
      ACT_RELEASE = 1'b1
   } action_type;

   typedef struct packed {
      logic             apply;
      logic             write;
      logic             shift;
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] tail;
      logic [POS_W-1:0] value;
   } cell_cmd_type;

   typedef struct packed {
      logic [POS_W-1:0] key;
      logic [LEN_W-1:0] len;
   } cell_query_type;

endpackage

`default_nettype wire

// ----- hdl/soru_if.sv -----
`default_nettype none

interface soru_req_if;
   logic                                  valid;
   logic                                  ready;
   soru_pkg::action_type                  action;
   logic [soru_pkg::SLOT_FIELD_W-1:0]     slot;

   modport source (output valid, output action, output slot, input ready);
   modport sink (input valid, input action, input slot, output ready);
endinterface

interface soru_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  granted;
   logic [soru_pkg::SLOT_FIELD_W-1:0]     slot_out;
   logic                                  reused;
   logic [soru_pkg::COUNT_FIELD_W-1:0]    active_count;

   modport source (output valid, output granted, output slot_out, output reused,
                   output active_count, input ready);
   modport sink (input valid, input granted, input slot_out, input reused,
                 input active_count, output ready);
endinterface

`default_nettype wire

// ----- hdl/soru_cell.sv -----
`default_nettype none

module soru_cell #(
   parameter int SLOT_W = 4,
   parameter int INDEX  = 0
) (
   input  wire logic                     clock,
   input  wire soru_pkg::cell_cmd_type   cmd,
   input  wire soru_pkg::cell_query_type query,
   input  wire logic [SLOT_W-1:0]        next_entry,
   output logic      [SLOT_W-1:0]        entry,
   output logic                          match
);

   localparam logic [soru_pkg::POS_W-1:0] MY_POS = soru_pkg::POS_W'(INDEX);
   localparam logic [soru_pkg::LEN_W-1:0] MY_LEN = soru_pkg::LEN_W'(INDEX);

   logic [SLOT_W-1:0] entry_ff;
   logic [SLOT_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.apply) begin
         if (cmd.write && (cmd.tail == MY_POS)) begin
            entry_in = cmd.value[SLOT_W-1:0];
         end else if (cmd.shift && (MY_POS >= cmd.pos)) begin
            entry_in = next_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   // only entries inside the list may match
   assign match = (soru_pkg::POS_W'(entry_ff) == query.key) && (MY_LEN < query.len);

endmodule

`default_nettype wire

// ----- hdl/slot_allocator_oldest_reuse_unit.sv -----
`default_nettype none

// Slot allocator with oldest-first reuse. An allocate request grants the lowest free slot
// below the pool size set in the csr register (0 counts as 1, values above MAX_SLOTS count
// as MAX_SLOTS) and appends it to an age list; with no free slot it takes the oldest listed
// slot, moves it to the tail and flags the response as reused. A release of an active slot
// clears it and removes it from the list; any other release answers with granted low. The
// age list lives in a row of MAX_SLOTS cells, each holding one entry and shifting toward
// the head on removal. Every request passes through two steps: one in which all cells compare
// their entry with the request and the free slot is picked, one in which the cells shift or
// write and the response register loads. A new request is taken in the cycle its predecessor
// commits, and a commit waits while the response register still holds an untaken transfer.
// No clearing pass follows reset.
module slot_allocator_oldest_reuse_unit #(
   parameter int MAX_SLOTS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   soru_req_if.sink                           req_bus,
   soru_rsp_if.source                         rsp_bus,
   input  wire logic                          csr_we,
   input  wire logic [soru_pkg::POOL_W-1:0]   csr_wdata
);

   localparam int SLOT_W = $clog2(MAX_SLOTS);
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int POS_W  = soru_pkg::POS_W;
   localparam int SF_W   = soru_pkg::SLOT_FIELD_W;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_EVAL  = 3'b010,
      ST_APPLY = 3'b100
   } state_type;

   state_type                    state_ff, state_in;
   logic [soru_pkg::POOL_W-1:0]  pool_ff, pool_in;
   logic [MAX_SLOTS-1:0]         act_ff, act_in;
   logic [CNT_W-1:0]             len_ff, len_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   soru_pkg::action_type         action_ff;
   logic [SF_W-1:0]              slot_ff;

   soru_pkg::cell_cmd_type       cmd_ff, cmd_in;
   logic [MAX_SLOTS-1:0]         pend_act_ff, pend_act_in;
   logic [CNT_W-1:0]             pend_len_ff, pend_len_in;
   logic                         res_granted_ff, res_granted_in;
   logic [SF_W-1:0]              res_slot_ff, res_slot_in;
   logic                         res_reused_ff, res_reused_in;

   logic                         out_granted_ff;
   logic [SF_W-1:0]              out_slot_ff;
   logic                         out_reused_ff;
   logic [CNT_W-1:0]             out_count_ff;

   logic                         out_free;
   logic                         apply_go;
   logic                         req_xfer;

   soru_pkg::cell_cmd_type       cell_cmd;
   soru_pkg::cell_query_type     cell_query;
   logic [SLOT_W-1:0]            entry [MAX_SLOTS];
   logic [SLOT_W-1:0]            next_entry [MAX_SLOTS];
   logic [MAX_SLOTS-1:0]         match;

   logic [MAX_SLOTS-1:0]         in_pool;
   logic [MAX_SLOTS-1:0]         free;
   logic [MAX_SLOTS-1:0]         free_oh;
   logic [MAX_SLOTS-1:0]         rel_oh;
   logic                         found;
   logic                         rel_hit;
   logic [SLOT_W-1:0]            free_idx;
   logic [POS_W-1:0]             match_pos;

   // handshake
   assign out_free        = !rsp_valid_ff || rsp_bus.ready;
   assign apply_go        = (state_ff == ST_APPLY) && out_free;
   assign req_bus.ready   = !reset && ((state_ff == ST_IDLE) || apply_go);
   assign req_xfer        = req_bus.valid && req_bus.ready;

   // cell row
   assign cell_query.key = POS_W'(slot_ff);
   assign cell_query.len = soru_pkg::LEN_W'(len_ff);

   always_comb begin
      cell_cmd       = cmd_ff;
      cell_cmd.apply = apply_go;
   end

   for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
      if (i == MAX_SLOTS - 1) begin : g_last
         assign next_entry[i] = entry[i];
      end else begin : g_mid
         assign next_entry[i] = entry[i+1];
      end

      soru_cell #(
         .SLOT_W (SLOT_W),
         .INDEX  (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .query      (cell_query),
         .next_entry (next_entry[i]),
         .entry      (entry[i]),
         .match      (match[i])
      );
   end

   // evaluation of the held request
   always_comb begin
      for (int s = 0; s < MAX_SLOTS; s++) begin
         in_pool[s] = (s == 0) || (s < int'(pool_ff));
         rel_oh[s]  = act_ff[s] && (int'(slot_ff) == s);
      end
      free    = ~act_ff & in_pool;
      free_oh = free & ~(free - MAX_SLOTS'(1));
      found   = |free;
      rel_hit = |rel_oh;

      free_idx  = '0;
      match_pos = '0;
      for (int s = 0; s < MAX_SLOTS; s++) begin
         if (free_oh[s]) begin
            free_idx = free_idx | SLOT_W'(s);
         end
         if (match[s]) begin
            match_pos = match_pos | POS_W'(s);
         end
      end

      cmd_in         = '0;
      pend_act_in    = act_ff;
      pend_len_in    = len_ff;
      res_granted_in = 1'b0;
      res_slot_in    = '0;
      res_reused_in  = 1'b0;

      if (action_ff == soru_pkg::ACT_ALLOC) begin
         if (found) begin
            cmd_in.write   = 1'b1;
            cmd_in.tail    = POS_W'(len_ff);
            cmd_in.value   = POS_W'(free_idx);
            pend_act_in    = act_ff | free_oh;
            pend_len_in    = len_ff + CNT_W'(1);
            res_granted_in = 1'b1;
            res_slot_in    = SF_W'(free_idx);
         end else if (len_ff != '0) begin
            // oldest entry goes to the tail
            cmd_in.shift   = 1'b1;
            cmd_in.pos     = '0;
            cmd_in.write   = 1'b1;
            cmd_in.tail    = POS_W'(len_ff - CNT_W'(1));
            cmd_in.value   = POS_W'(entry[0]);
            res_granted_in = 1'b1;
            res_slot_in    = SF_W'(entry[0]);
            res_reused_in  = 1'b1;
         end
      end else if (rel_hit) begin
         cmd_in.shift   = 1'b1;
         cmd_in.pos     = match_pos;
         pend_act_in    = act_ff & ~rel_oh;
         pend_len_in    = len_ff - CNT_W'(1);
         res_granted_in = 1'b1;
         res_slot_in    = slot_ff;
      end
   end

   // control state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (apply_go) begin
               state_in = req_xfer ? ST_EVAL : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      pool_in = csr_we ? csr_wdata : pool_ff;
      act_in  = apply_go ? pend_act_ff : act_ff;
      len_in  = apply_go ? pend_len_ff : len_ff;

      if (apply_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pool_ff      <= soru_pkg::POOL_RESET;
         act_ff       <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pool_ff      <= pool_in;
         act_ff       <= act_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         action_ff <= req_bus.action;
         slot_ff   <= req_bus.slot;
      end
      if (state_ff == ST_EVAL) begin
         cmd_ff         <= cmd_in;
         pend_act_ff    <= pend_act_in;
         pend_len_ff    <= pend_len_in;
         res_granted_ff <= res_granted_in;
         res_slot_ff    <= res_slot_in;
         res_reused_ff  <= res_reused_in;
      end
      if (apply_go) begin
         out_granted_ff <= res_granted_ff;
         out_slot_ff    <= res_slot_ff;
         out_reused_ff  <= res_reused_ff;
         out_count_ff   <= pend_len_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.granted      = out_granted_ff;
   assign rsp_bus.slot_out     = out_slot_ff;
   assign rsp_bus.reused       = out_reused_ff;
   assign rsp_bus.active_count = soru_pkg::COUNT_FIELD_W'(out_count_ff);

`ifndef SYNTHESIS
   a_count_matches_list: assert property (@(posedge clock) disable iff (reset)
      $countones(act_ff) == int'(len_ff))
      else $error("active bits disagree with list length");

   a_unique_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match))
      else $error("slot listed more than once");

   a_release_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) && (action_ff == soru_pkg::ACT_RELEASE) && rel_hit
      |-> (match != '0))
      else $error("active slot missing from list");

   a_full_pool_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) && (action_ff == soru_pkg::ACT_ALLOC) && !found
      |-> (len_ff != '0))
      else $error("no free slot and empty list");
`endif

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   localparam int POOL_MAX       = 16;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MISMATCH_SHOWN = 10;
   localparam int RX_HOLD_LEN    = 80;

   typedef struct packed {
      logic                               granted;
      logic [soru_pkg::SLOT_FIELD_W-1:0]  slot_out;
      logic                               reused;
      logic [soru_pkg::COUNT_FIELD_W-1:0] active_count;
   } grant_type;

   typedef struct packed {
      logic      typed;
      grant_type want;
   } pin_type;

   typedef enum logic {
      STEP_REQ  = 1'b0,
      STEP_POOL = 1'b1
   } step_kind_type;

   typedef struct packed {
      step_kind_type                     kind;
      soru_pkg::action_type              act;
      logic [soru_pkg::SLOT_FIELD_W-1:0] slot;
      logic [soru_pkg::POOL_W-1:0]       pool;
      logic                              typed;
      grant_type                         want;
   } plan_row_type;

   localparam grant_type NO_GRANT = '0;
   localparam int PLAN_LEN = 22;

   localparam plan_row_type DIRECTED_PLAN [PLAN_LEN] = '{
      '{STEP_REQ,  soru_pkg::ACT_RELEASE, 4'd0,  5'd0,  1'b1, '{1'b0, 4'd0, 1'b0, 5'd0}},
      '{STEP_REQ,  soru_pkg::ACT_RELEASE, 4'd15, 5'd0,  1'b1, '{1'b0, 4'd0, 1'b0, 5'd0}},
      '{STEP_REQ,  soru_pkg::ACT_ALLOC,   4'd15, 5'd0,  1'b1, '{1'b1, 4'd0, 1'b0, 5'd1}},
      '{STEP_REQ,  soru_pkg::ACT_ALLOC,   4'd0,  5'd0,  1'b1, '{1'b1, 4'd1, 1'b0, 5'd2}},
      '{STEP_REQ,  soru_pkg::ACT_RELEASE, 4'd0,  5'd0,  1'b1, '{1'b1, 4'd0, 1'b0, 5'd1}},
      '{STEP_REQ,  soru_pkg::ACT_ALLOC,   4'd10, 5'd0,  1'b0, NO_GRANT},
      '{STEP_POOL, soru_pkg::ACT_ALLOC,   4'd0,  5'd1,  1'b0, NO_GRANT},
      '{STEP_REQ,  soru_pkg::ACT_ALLOC,   4'd5,  5'd0,  1'b0, NO_GRANT},
      '{STEP_REQ,  soru_pkg::ACT_ALLOC,   4'd0,  5'd0,  1'b0, NO_GRANT},
      '{STEP_REQ,  soru_pkg::ACT_RELEASE, 4'd1,  5'd0,  1'b0, NO_GRANT},
      '{STEP_REQ,  soru_pkg::ACT_RELEASE, 4'd0,  5'd0,  1'b0, NO_GRANT},
      '{STEP_REQ,  soru_pkg::ACT_ALLOC,   4'd0,  5'd0,  1'b0, NO_GRANT},
      '{STEP_REQ,  soru_pkg::ACT_ALLOC,   4'd0,  5'd0,  1'b0, NO_GRANT},
      '{STEP_POOL, soru_pkg::ACT_ALLOC,   4'd0,  5'd0,  1'b0, NO_GRANT},
      '{STEP_REQ,  soru_pkg::ACT_ALLOC,   4'd7,  5'd0,  1'b0, NO_GRANT},
      '{STEP_REQ,  soru_pkg::ACT_RELEASE, 4'd0,  5'd0,  1'b0, NO_GRANT},
      '{STEP_REQ,  soru_pkg::ACT_ALLOC,   4'd0,  5'd0,  1'b0, NO_GRANT},
      '{STEP_POOL, soru_pkg::ACT_ALLOC,   4'd0,  5'd31, 1'b0, NO_GRANT},
      '{STEP_REQ,  soru_pkg::ACT_ALLOC,   4'd0,  5'd0,  1'b0, NO_GRANT},
      '{STEP_REQ,  soru_pkg::ACT_RELEASE, 4'd15, 5'd0,  1'b0, NO_GRANT},
      '{STEP_REQ,  soru_pkg::ACT_RELEASE, 4'd10, 5'd0,  1'b0, NO_GRANT},
      '{STEP_POOL, soru_pkg::ACT_ALLOC,   4'd0,  5'd16, 1'b0, NO_GRANT}
   };

   localparam logic [soru_pkg::POOL_W-1:0] PHASE_POOLS [8] = '{
      5'd16, 5'd2, 5'd31, 5'd1, 5'd9, 5'd0, 5'd16, 5'd20
   };

   logic clock;
   logic reset;
   logic csr_we;
   logic [soru_pkg::POOL_W-1:0] csr_wdata;

   soru_req_if req_bus ();
   soru_rsp_if rsp_bus ();

   slot_allocator_oldest_reuse_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [POOL_MAX-1:0]               live_slots = '0;
   logic [soru_pkg::SLOT_FIELD_W-1:0] age_order [$];
   logic [soru_pkg::POOL_W-1:0]       pool_cfg = soru_pkg::POOL_RESET;

   grant_type grants_due [$];
   pin_type   pinned_q [$];

   int mismatches     = 0;
   int idle_cycles    = 0;
   int tx_idle_pct    = 0;
   int rx_idle_pct    = 0;
   int rx_hold_cycles = 0;
   int hold_asked     = 0;
   int hold_taken     = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic predict_grant(input soru_pkg::action_type act,
                                input logic [soru_pkg::SLOT_FIELD_W-1:0] slot_id,
                                output grant_type g);
      int limit;
      int pick;
      int idx;
      g = '0;
      limit = (pool_cfg == 0) ? 1 : ((pool_cfg > POOL_MAX) ? POOL_MAX : int'(pool_cfg));
      if (act == soru_pkg::ACT_ALLOC) begin
         pick = -1;
         for (idx = 0; idx < limit; idx++)
            if (!live_slots[idx] && pick < 0) pick = idx;
         if (pick >= 0) begin
            live_slots[pick] = 1'b1;
            age_order.push_back(pick[soru_pkg::SLOT_FIELD_W-1:0]);
            g.granted  = 1'b1;
            g.slot_out = pick[soru_pkg::SLOT_FIELD_W-1:0];
         end else if (age_order.size() > 0) begin
            // oldest goes to the tail
            g.slot_out = age_order.pop_front();
            age_order.push_back(g.slot_out);
            g.granted  = 1'b1;
            g.reused   = 1'b1;
         end
      end else if (live_slots[slot_id]) begin
         live_slots[slot_id] = 1'b0;
         for (idx = 0; idx < age_order.size(); idx++) begin
            if (age_order[idx] == slot_id) begin
               age_order.delete(idx);
               break;
            end
         end
         g.granted  = 1'b1;
         g.slot_out = slot_id;
      end
      g.active_count = soru_pkg::COUNT_FIELD_W'(age_order.size());
   endtask

   function automatic bit hold_active();
      return rx_hold_cycles > 0;
   endfunction

   always @(posedge clock) begin
      if (hold_taken != hold_asked) begin
         hold_taken     <= hold_asked;
         rx_hold_cycles <= RX_HOLD_LEN;
         rsp_bus.ready  <= 1'b0;
      end else if (hold_active()) begin
         rsp_bus.ready <= 1'b0;
         rx_hold_cycles <= rx_hold_cycles - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      grant_type calc;
      grant_type want;
      pin_type   pin;
      bit        moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_bus.valid && req_bus.ready) begin
            moved = 1'b1;
            predict_grant(req_bus.action, req_bus.slot, calc);
            pin = pinned_q.pop_front();
            grants_due.push_back(pin.typed ? pin.want : calc);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            if (grants_due.size() == 0) begin
               mismatches++;
               if (mismatches <= MISMATCH_SHOWN)
                  $display("unexpected transfer: granted=%0d slot=%0d reused=%0d count=%0d",
                           rsp_bus.granted, rsp_bus.slot_out, rsp_bus.reused,
                           rsp_bus.active_count);
            end else begin
               want = grants_due.pop_front();
               if (rsp_bus.granted !== want.granted || rsp_bus.slot_out !== want.slot_out ||
                   rsp_bus.reused !== want.reused ||
                   rsp_bus.active_count !== want.active_count) begin
                  mismatches++;
                  if (mismatches <= MISMATCH_SHOWN)
                     $display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                              want.granted, want.slot_out, want.reused, want.active_count,
                              rsp_bus.granted, rsp_bus.slot_out, rsp_bus.reused,
                              rsp_bus.active_count);
               end
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic send_request(input soru_pkg::action_type act,
                               input logic [soru_pkg::SLOT_FIELD_W-1:0] slot_id,
                               input logic typed, input grant_type want);
      pin_type pin;
      pin.typed = typed;
      pin.want  = want;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      pinned_q.push_back(pin);
      req_bus.valid  <= 1'b1;
      req_bus.action <= act;
      req_bus.slot   <= slot_id;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (grants_due.size() != 0 || pinned_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_pool(input logic [soru_pkg::POOL_W-1:0] value);
      wait_drained();
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      pool_cfg = value;
      @(posedge clock);
   endtask

   task automatic random_request(input int alloc_pct);
      soru_pkg::action_type act;
      logic [soru_pkg::SLOT_FIELD_W-1:0] slot_id;
      act = ($urandom_range(99) < alloc_pct) ? soru_pkg::ACT_ALLOC : soru_pkg::ACT_RELEASE;
      slot_id = soru_pkg::SLOT_FIELD_W'($urandom_range(POOL_MAX - 1));
      // mostly release something that is live
      if (act == soru_pkg::ACT_RELEASE && age_order.size() > 0 && $urandom_range(9) < 7)
         slot_id = age_order[$urandom_range(age_order.size() - 1)];
      send_request(act, slot_id, 1'b0, NO_GRANT);
   endtask

   initial begin
      int row;
      int phase;
      int n;
      int alloc_pct;
      req_bus.valid  <= 1'b0;
      req_bus.action <= soru_pkg::ACT_ALLOC;
      req_bus.slot   <= '0;
      csr_we         <= 1'b0;
      csr_wdata      <= '0;
      reset          <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (row = 0; row < PLAN_LEN; row++) begin
         if (DIRECTED_PLAN[row].kind == STEP_POOL)
            write_pool(DIRECTED_PLAN[row].pool);
         else
            send_request(DIRECTED_PLAN[row].act, DIRECTED_PLAN[row].slot,
                         DIRECTED_PLAN[row].typed, DIRECTED_PLAN[row].want);
      end

      for (phase = 0; phase < 8; phase++) begin
         write_pool((phase == 7) ? soru_pkg::POOL_W'($urandom_range(31)) : PHASE_POOLS[phase]);
         tx_idle_pct = (phase < 3) ? 20 : ((phase < 6) ? 72 : 0);
         rx_idle_pct = (phase < 3) ? 72 : ((phase < 6) ? 20 : 0);
         alloc_pct   = $urandom_range(80, 45);
         for (n = 0; n < 100; n++) begin
            // long receiver stall so the block backs up into its input
            if (phase == 6 && n == 30) hold_asked = hold_asked + 1;
            random_request(alloc_pct);
         end
      end

      wait_drained();
      repeat (6) @(posedge clock);
      if (mismatches == 0 && grants_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
